// File: src/qse_pkg.sv
// Shared types, sizes and command codes for the quicksort engine.
`default_nettype none

package qse_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int DATA_WIDTH   = 32;
    localparam int STACK_DEPTH  = 64;

    localparam int IDXW  = $clog2(MAX_ELEMENTS);      // element address
    localparam int CNTW  = $clog2(MAX_ELEMENTS + 1);  // element count
    localparam int POSW  = IDXW + 2;                  // signed scan position
    localparam int STKIW = $clog2(STACK_DEPTH);       // stack address
    localparam int SPW   = $clog2(STACK_DEPTH + 1);   // stack pointer

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic signed [POSW-1:0]       t_pos;
    typedef logic [2*IDXW-1:0]            t_range;   // {lo, hi}

    typedef struct packed {
        t_data value;
        logic  is_last;
    } t_in_word;

    typedef struct packed {
        t_data sorted_value;
        logic  end_of_run;
        logic  overflow;
    } t_out_word;

    // store read address select
    localparam logic [1:0] R_K   = 2'd0;
    localparam logic [1:0] R_MID = 2'd1;
    localparam logic [1:0] R_I   = 2'd2;
    localparam logic [1:0] R_J   = 2'd3;

    // store write select
    localparam logic [1:0] W_LOAD = 2'd0;
    localparam logic [1:0] W_I_AJ = 2'd1;
    localparam logic [1:0] W_J_AI = 2'd2;

    // range push select
    localparam logic [1:0] P_FULL  = 2'd0;
    localparam logic [1:0] P_RIGHT = 2'd1;
    localparam logic [1:0] P_LEFT  = 2'd2;

    typedef struct packed {
        logic       store_we;
        logic [1:0] wsel;
        logic [1:0] raddr_sel;
        logic       count_inc;
        logic       drop_set;
        logic       run_clear;
        logic       push_en;
        logic [1:0] push_sel;
        logic       pop;
        logic       range_load;
        logic       pivot_load;
        logic       ai_load;
        logic       aj_load;
        logic       i_inc;
        logic       j_dec;
        logic       k_inc;
    } t_cmd;

    typedef struct packed {
        logic count_full;
        logic count_lt2;
        logic sp_zero;
        logic i_le_j;
        logic i_le_hi;
        logic j_ge_lo;
        logic i_lt_hi;
        logic j_gt_lo;
        logic key_lt;
        logic key_gt;
        logic k_last;
    } t_status;

endpackage

`default_nettype wire

// File: src/qse_datapath.sv
// Datapath: element store, range stack, scan indices, pivot and run counters.
`default_nettype none

module qse_datapath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire qse_pkg::t_in_word   i_in_word,
    input  wire qse_pkg::t_cmd       i_cmd,
    output qse_pkg::t_status         o_status,
    output qse_pkg::t_out_word       o_out_word
);

    // memories
    qse_pkg::t_data  r_store [qse_pkg::MAX_ELEMENTS];
    qse_pkg::t_range r_stack [qse_pkg::STACK_DEPTH];
    qse_pkg::t_data  r_store_rd;
    qse_pkg::t_range r_stack_rd;

    // control registers
    logic [qse_pkg::CNTW-1:0] r_count, n_count;
    logic [qse_pkg::SPW-1:0]  r_sp, n_sp;
    logic                     r_dropped, n_dropped;
    logic [qse_pkg::IDXW-1:0] r_k, n_k;

    // payload registers
    qse_pkg::t_pos  r_lo, r_hi, r_i, r_j;
    qse_pkg::t_data r_pivot, r_ai, r_aj;

    logic [qse_pkg::POSW-1:0]  w_mid_sum;
    logic [qse_pkg::IDXW-1:0]  w_raddr, w_waddr;
    qse_pkg::t_data            w_wdata;
    qse_pkg::t_range           w_push_data;
    logic [qse_pkg::CNTW-1:0]  w_cnt_m1;
    logic                      w_push_ok;
    logic [qse_pkg::SPW-1:0]   w_sp_m1;

    assign w_mid_sum = r_lo + r_hi;
    assign w_cnt_m1  = r_count - 1'b1;
    assign w_push_ok = r_sp < qse_pkg::SPW'(qse_pkg::STACK_DEPTH);
    assign w_sp_m1   = r_sp - 1'b1;

    always_comb begin
        case (i_cmd.raddr_sel)
            qse_pkg::R_MID: w_raddr = w_mid_sum[qse_pkg::IDXW:1];
            qse_pkg::R_I:   w_raddr = r_i[qse_pkg::IDXW-1:0];
            qse_pkg::R_J:   w_raddr = r_j[qse_pkg::IDXW-1:0];
            default:        w_raddr = r_k;
        endcase
    end

    always_comb begin
        case (i_cmd.wsel)
            qse_pkg::W_I_AJ: begin
                w_waddr = r_i[qse_pkg::IDXW-1:0];
                w_wdata = r_aj;
            end
            qse_pkg::W_J_AI: begin
                w_waddr = r_j[qse_pkg::IDXW-1:0];
                w_wdata = r_ai;
            end
            default: begin
                w_waddr = r_count[qse_pkg::IDXW-1:0];
                w_wdata = i_in_word.value;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.push_sel)
            qse_pkg::P_RIGHT: w_push_data = {r_i[qse_pkg::IDXW-1:0], r_hi[qse_pkg::IDXW-1:0]};
            qse_pkg::P_LEFT:  w_push_data = {r_lo[qse_pkg::IDXW-1:0], r_j[qse_pkg::IDXW-1:0]};
            default:          w_push_data = {{qse_pkg::IDXW{1'b0}},
                                             w_cnt_m1[qse_pkg::IDXW-1:0]};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_we) begin
            r_store[w_waddr] <= w_wdata;
        end
        r_store_rd <= r_store[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_en && w_push_ok) begin
            r_stack[r_sp[qse_pkg::STKIW-1:0]] <= w_push_data;
        end
        if (i_cmd.pop) begin
            r_stack_rd <= r_stack[w_sp_m1[qse_pkg::STKIW-1:0]];
        end
    end

    always_comb begin
        n_count   = r_count;
        n_sp      = r_sp;
        n_dropped = r_dropped;
        n_k       = r_k;
        if (i_cmd.count_inc) n_count = r_count + 1'b1;
        if (i_cmd.drop_set)  n_dropped = 1'b1;
        if (i_cmd.push_en && w_push_ok) n_sp = r_sp + 1'b1;
        if (i_cmd.pop)       n_sp = w_sp_m1;
        if (i_cmd.k_inc)     n_k = r_k + 1'b1;
        if (i_cmd.run_clear) begin
            n_count   = '0;
            n_sp      = '0;
            n_dropped = 1'b0;
            n_k       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_sp      <= '0;
            r_dropped <= 1'b0;
            r_k       <= '0;
        end else begin
            r_count   <= n_count;
            r_sp      <= n_sp;
            r_dropped <= n_dropped;
            r_k       <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.range_load) begin
            r_lo <= qse_pkg::t_pos'({2'b00, r_stack_rd[2*qse_pkg::IDXW-1:qse_pkg::IDXW]});
            r_hi <= qse_pkg::t_pos'({2'b00, r_stack_rd[qse_pkg::IDXW-1:0]});
            r_i  <= qse_pkg::t_pos'({2'b00, r_stack_rd[2*qse_pkg::IDXW-1:qse_pkg::IDXW]});
            r_j  <= qse_pkg::t_pos'({2'b00, r_stack_rd[qse_pkg::IDXW-1:0]});
        end else begin
            if (i_cmd.i_inc) r_i <= r_i + qse_pkg::t_pos'(1);
            if (i_cmd.j_dec) r_j <= r_j - qse_pkg::t_pos'(1);
        end
        if (i_cmd.pivot_load) r_pivot <= r_store_rd;
        if (i_cmd.ai_load)    r_ai    <= r_store_rd;
        if (i_cmd.aj_load)    r_aj    <= r_store_rd;
    end

    assign o_status.count_full = r_count == qse_pkg::CNTW'(qse_pkg::MAX_ELEMENTS);
    assign o_status.count_lt2  = r_count < qse_pkg::CNTW'(2);
    assign o_status.sp_zero    = r_sp == '0;
    assign o_status.i_le_j     = r_i <= r_j;
    assign o_status.i_le_hi    = r_i <= r_hi;
    assign o_status.j_ge_lo    = r_j >= r_lo;
    assign o_status.i_lt_hi    = r_i < r_hi;
    assign o_status.j_gt_lo    = r_j > r_lo;
    assign o_status.key_lt     = r_store_rd < r_pivot;
    assign o_status.key_gt     = r_store_rd > r_pivot;
    assign o_status.k_last     = qse_pkg::CNTW'(r_k) == w_cnt_m1;

    assign o_out_word.sorted_value = r_store_rd;
    assign o_out_word.end_of_run   = o_status.k_last;
    assign o_out_word.overflow     = r_dropped;

endmodule

`default_nettype wire

// File: src/qse_ctrl.sv
// Controller: load, partition sequencing and emit state machine.
`default_nettype none

module qse_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_last,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire qse_pkg::t_status i_status,
    output qse_pkg::t_cmd         o_cmd
);

    localparam logic [4:0] S_LOAD      = 5'd0;
    localparam logic [4:0] S_SORT_INIT = 5'd1;
    localparam logic [4:0] S_POP       = 5'd2;
    localparam logic [4:0] S_POP_WAIT  = 5'd3;
    localparam logic [4:0] S_PIV_RD    = 5'd4;
    localparam logic [4:0] S_PIV_LATCH = 5'd5;
    localparam logic [4:0] S_LOOP_CHK  = 5'd6;
    localparam logic [4:0] S_SCAN_I    = 5'd7;
    localparam logic [4:0] S_SCAN_I_CMP = 5'd8;
    localparam logic [4:0] S_SCAN_J    = 5'd9;
    localparam logic [4:0] S_SCAN_J_CMP = 5'd10;
    localparam logic [4:0] S_SWAP_CHK  = 5'd11;
    localparam logic [4:0] S_SWAP2     = 5'd12;
    localparam logic [4:0] S_FINISH    = 5'd13;
    localparam logic [4:0] S_FINISH2   = 5'd14;
    localparam logic [4:0] S_EMIT_RD   = 5'd15;
    localparam logic [4:0] S_EMIT_HOLD = 5'd16;

    logic [4:0] r_state, n_state;

    assign o_in_ready  = r_state == S_LOAD;
    assign o_out_valid = r_state == S_EMIT_HOLD;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.raddr_sel = qse_pkg::R_K;
        o_cmd.wsel      = qse_pkg::W_LOAD;
        o_cmd.push_sel  = qse_pkg::P_FULL;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    if (i_status.count_full) begin
                        o_cmd.drop_set = 1'b1;
                    end else begin
                        o_cmd.store_we  = 1'b1;
                        o_cmd.count_inc = 1'b1;
                    end
                    if (i_in_last) n_state = S_SORT_INIT;
                end
            end
            S_SORT_INIT: begin
                if (i_status.count_lt2) begin
                    n_state = S_EMIT_RD;
                end else begin
                    o_cmd.push_en = 1'b1;
                    n_state       = S_POP;
                end
            end
            S_POP: begin
                if (i_status.sp_zero) begin
                    n_state = S_EMIT_RD;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_POP_WAIT;
                end
            end
            S_POP_WAIT: begin
                o_cmd.range_load = 1'b1;
                n_state          = S_PIV_RD;
            end
            S_PIV_RD: begin
                o_cmd.raddr_sel = qse_pkg::R_MID;
                n_state         = S_PIV_LATCH;
            end
            S_PIV_LATCH: begin
                o_cmd.pivot_load = 1'b1;
                n_state          = S_LOOP_CHK;
            end
            S_LOOP_CHK: begin
                n_state = i_status.i_le_j ? S_SCAN_I : S_FINISH;
            end
            S_SCAN_I: begin
                o_cmd.raddr_sel = qse_pkg::R_I;
                n_state = i_status.i_le_hi ? S_SCAN_I_CMP : S_SCAN_J;
            end
            S_SCAN_I_CMP: begin
                if (i_status.key_lt) begin
                    o_cmd.i_inc = 1'b1;
                    n_state     = S_SCAN_I;
                end else begin
                    o_cmd.ai_load = 1'b1;
                    n_state       = S_SCAN_J;
                end
            end
            S_SCAN_J: begin
                o_cmd.raddr_sel = qse_pkg::R_J;
                n_state = i_status.j_ge_lo ? S_SCAN_J_CMP : S_SWAP_CHK;
            end
            S_SCAN_J_CMP: begin
                if (i_status.key_gt) begin
                    o_cmd.j_dec = 1'b1;
                    n_state     = S_SCAN_J;
                end else begin
                    o_cmd.aj_load = 1'b1;
                    n_state       = S_SWAP_CHK;
                end
            end
            S_SWAP_CHK: begin
                if (i_status.i_le_j) begin
                    o_cmd.store_we = 1'b1;
                    o_cmd.wsel     = qse_pkg::W_I_AJ;
                    n_state        = S_SWAP2;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SWAP2: begin
                o_cmd.store_we = 1'b1;
                o_cmd.wsel     = qse_pkg::W_J_AI;
                o_cmd.i_inc    = 1'b1;
                o_cmd.j_dec    = 1'b1;
                n_state        = S_LOOP_CHK;
            end
            S_FINISH: begin
                if (i_status.i_lt_hi) begin
                    o_cmd.push_en  = 1'b1;
                    o_cmd.push_sel = qse_pkg::P_RIGHT;
                end
                n_state = S_FINISH2;
            end
            S_FINISH2: begin
                if (i_status.j_gt_lo) begin
                    o_cmd.push_en  = 1'b1;
                    o_cmd.push_sel = qse_pkg::P_LEFT;
                end
                n_state = S_POP;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_HOLD;
            end
            S_EMIT_HOLD: begin
                if (i_out_ready) begin
                    if (i_status.k_last) begin
                        o_cmd.run_clear = 1'b1;
                        n_state         = S_LOAD;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                        n_state     = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: src/quicksort_engine.sv
// Top level of the quicksort engine: controller plus datapath.
//
// Input channel (i_in_valid / o_in_ready / i_in_word): one word per element.
// Words are written into a 64-entry element store at one word per cycle while
// o_in_ready is high. A word with is_last set closes the run; words arriving
// with the store full are dropped and the run's results carry overflow = 1
// (a dropped is_last word still closes the run).
// After the last word the block sorts the run in place with Hoare-partition
// quicksort, middle element as pivot, using an explicit range stack. The
// element store has one registered read port and one write port: each scan
// step is a read state then a compare state, each swap writes one element in
// S_SWAP_CHK and the other in S_SWAP2, and each partition adds pop, pivot
// and push states. Output channel (o_out_valid / i_out_ready / o_out_word):
// the run in ascending order, each word read from the store in S_EMIT_RD and
// held in S_EMIT_HOLD until taken, end_of_run set on the final word. A stalled
// receiver simply holds the current word; nothing is lost. o_in_ready stays
// low from the last input word until the final result word is taken.
// Reset (synchronous, active low) empties the store and stack counters and
// returns to loading; store contents are not cleared.
`default_nettype none

module quicksort_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire qse_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output qse_pkg::t_out_word      o_out_word
);

    // command and status between sequencer and datapath
    qse_pkg::t_cmd    w_cmd;
    qse_pkg::t_status w_status;

    qse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_word.is_last),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // store, stack, scan indices and the output word
    qse_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out_word (o_out_word)
    );

endmodule

`default_nettype wire

// File: src/qse_checker.sv
// Port-level checks for the quicksort engine, bound to the top level.
`default_nettype none

module qse_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire qse_pkg::t_in_word  i_in_word,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire qse_pkg::t_out_word o_out_word
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)))
        else $error("result word changed while stalled");

    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while result valid");

    // closing word stops loading
    a_last_stops_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_word.is_last) |=> !o_in_ready)
        else $error("still loading after last word");

    // final result returns to loading
    a_end_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_word.end_of_run) |=>
            (!o_out_valid && o_in_ready))
        else $error("no return to loading after end of run");

endmodule

bind quicksort_engine qse_checker u_qse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

`default_nettype wire
